[design/ray_sphere_closest_hit_assert.svh]
// Assertion macros for the ray/sphere closest-hit block.
`ifndef RAY_SPHERE_CLOSEST_HIT_ASSERT_SVH
`define RAY_SPHERE_CLOSEST_HIT_ASSERT_SVH
`ifndef SYNTH
`define RSCH_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define RSCH_ASSERT_ALW(lbl, ck, rn, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) else $error(msg);
`else
`define RSCH_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define RSCH_ASSERT_ALW(lbl, ck, rn, expr, msg)
`endif
`endif

[design/rsch_pkg.sv]
`timescale 1ns / 1ps
package rsch_pkg;
	localparam int SPHERE_COUNT = 8;
	localparam int IDX_W = (SPHERE_COUNT > 1) ? $clog2(SPHERE_COUNT) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int ACC_W = 66;
	localparam int DIV_W = 50;
	localparam int DIVISOR_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int ROOT_W = 32;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int SQ_CNT_W = $clog2(ROOT_W);
	localparam logic signed [31:0] EPS_RAW = 32'sd6;
	localparam logic [DIV_W-1:0] NORM_MAX = DIV_W'(65536);
	localparam logic [DIV_W-1:0] POS_LIM = DIV_W'(64'h7FFF_FFFF);
	localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(64'h8000_0000);
	localparam logic signed [ACC_W-1:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [ACC_W-1:0] S32_MIN = -66'sd2147483648;

	typedef enum logic {OP_LOAD, OP_RAY} op_t;

	typedef enum logic [2:0] {PH_A, PH_H, PH_C, PH_D, PH_P, PH_N} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SPH, ST_MUL, ST_ACC, ST_NEXT,
		ST_SQ_GO, ST_SQ_WAIT, ST_DV_GO, ST_DV_WAIT, ST_RES
	} eng_state_t;

	typedef struct packed {
		op_t op;
		logic [2:0] slot;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic [30:0] radius;
		logic [7:0] material;
	} item_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) r = 32'sh7FFF_FFFF;
		else if (v < S32_MIN) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	// floor(p / 65536)
	function automatic logic signed [ACC_W-1:0] f16(input logic signed [63:0] p);
		return ACC_W'(p >>> 16);
	endfunction
endpackage

[design/rsch_front.sv]
`timescale 1ns / 1ps
module rsch_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic action,
	input logic [2:0] slot,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] pos_z,
	input logic signed [31:0] dir_x,
	input logic signed [31:0] dir_y,
	input logic signed [31:0] dir_z,
	input logic [30:0] radius,
	input logic [7:0] material_id,
	output logic avail,
	output rsch_pkg::item_t head,
	input logic take
);
	rsch_pkg::item_t q_q [rsch_pkg::QUEUE_DEPTH];
	logic [rsch_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [rsch_pkg::QPTR_W:0] cnt_q;
	rsch_pkg::item_t item;
	logic keep, wr_en, rd_en;

	// loads to slots beyond the table are accepted and dropped here
	assign keep = action | (32'(slot) < rsch_pkg::SPHERE_COUNT);
	assign full = (cnt_q == (rsch_pkg::QPTR_W + 1)'(rsch_pkg::QUEUE_DEPTH));
	assign avail = (cnt_q != '0);
	assign wr_en = push & ~full & keep;
	assign rd_en = take & avail;
	assign head = q_q[rd_q];

	always_comb begin
		item.op = action ? rsch_pkg::OP_RAY : rsch_pkg::OP_LOAD;
		item.slot = slot;
		item.px = pos_x;
		item.py = pos_y;
		item.pz = pos_z;
		item.dx = dir_x;
		item.dy = dir_y;
		item.dz = dir_z;
		item.radius = radius;
		item.material = material_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == rsch_pkg::QPTR_W'(rsch_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == rsch_pkg::QPTR_W'(rsch_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_q[wr_q] <= item;
		end
	end
endmodule

[design/rsch_sqrt.sv]
`timescale 1ns / 1ps
module rsch_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [rsch_pkg::RAD_W-1:0] radicand,
	output logic done,
	output logic [rsch_pkg::ROOT_W-1:0] root
);
	logic [rsch_pkg::RAD_W-1:0] rad_q;
	logic [rsch_pkg::ROOT_W+3:0] rem_q, rem_sh, trial;
	logic [rsch_pkg::ROOT_W-1:0] root_q;
	logic [rsch_pkg::SQ_CNT_W-1:0] cnt_q;
	logic busy_q, done_q, ge;

	// two radicand bits per step
	assign rem_sh = {rem_q[rsch_pkg::ROOT_W+1:0], rad_q[rsch_pkg::RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge = (rem_sh >= trial);
	assign done = done_q;
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rsch_pkg::SQ_CNT_W'(rsch_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			rem_q <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[rsch_pkg::ROOT_W-2:0], ge};
		end
	end
endmodule

[design/rsch_div.sv]
`timescale 1ns / 1ps
module rsch_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [rsch_pkg::DIV_W-1:0] dividend,
	input logic [rsch_pkg::DIVISOR_W-1:0] divisor,
	output logic done,
	output logic [rsch_pkg::DIV_W-1:0] quot
);
	logic [rsch_pkg::DIV_W-1:0] q_q;
	logic [rsch_pkg::DIVISOR_W-1:0] dvs_q;
	logic [rsch_pkg::DIVISOR_W:0] rem_q, r2;
	logic [rsch_pkg::DIV_CNT_W-1:0] cnt_q;
	logic busy_q, done_q, ge;

	// restoring, one quotient bit per step
	assign r2 = {rem_q[rsch_pkg::DIVISOR_W-1:0], q_q[rsch_pkg::DIV_W-1]};
	assign ge = (r2 >= {1'b0, dvs_q});
	assign done = done_q;
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rsch_pkg::DIV_CNT_W'(rsch_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? r2 - {1'b0, dvs_q} : r2;
			q_q <= {q_q[rsch_pkg::DIV_W-2:0], ge};
		end
	end
endmodule

[design/rsch_engine.sv]
`timescale 1ns / 1ps
module rsch_engine (
	input logic clk,
	input logic arst_n,
	input logic avail,
	input rsch_pkg::item_t head,
	output logic take,
	input logic pop,
	output logic empty,
	output logic hit,
	output logic signed [31:0] distance,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic signed [17:0] normal_z,
	output logic [7:0] hit_material
);
	rsch_pkg::eng_state_t state_q, state_d;
	rsch_pkg::phase_t phase_q;
	logic [1:0] pc_q;
	logic [rsch_pkg::IDX_W-1:0] i_q, load_idx;
	logic [rsch_pkg::SPHERE_COUNT-1:0] valid_q;
	logic found_q, out_valid_q;

	logic signed [31:0] cx_q [rsch_pkg::SPHERE_COUNT];
	logic signed [31:0] cy_q [rsch_pkg::SPHERE_COUNT];
	logic signed [31:0] cz_q [rsch_pkg::SPHERE_COUNT];
	logic [30:0] rad_q [rsch_pkg::SPHERE_COUNT];
	logic [7:0] mat_q [rsch_pkg::SPHERE_COUNT];

	logic signed [31:0] o_q [3];
	logic signed [31:0] d_q [3];
	logic signed [31:0] oc_q [3];
	logic signed [31:0] p_q [3];
	logic signed [31:0] n_q [3];
	logic signed [31:0] cen_q [3];
	logic signed [17:0] norm_q [3];
	logic signed [31:0] a_q, h_q, c_q, best_t_q;
	logic [7:0] best_mat_q;
	logic tneg_q;

	logic signed [63:0] prod_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [rsch_pkg::ACC_W-1:0] acc_q, acc_nx, term;
	logic last_pc;
	logic signed [31:0] p_nx, n_nx;

	logic sq_start, sq_done, dv_start, dv_done, out_load;
	logic [rsch_pkg::ROOT_W-1:0] sq_root;
	logic [rsch_pkg::DIV_W-1:0] dv_dividend, quot;
	logic [rsch_pkg::DIVISOR_W-1:0] dv_divisor;
	logic signed [33:0] num;
	logic [33:0] num_mag;
	logic signed [31:0] nsel;
	logic [31:0] nmag;
	logic signed [31:0] t_pos, t_neg, t_val;
	logic [17:0] nm;
	logic signed [17:0] nv;
	logic better;

	logic hit_q;
	logic signed [31:0] dist_q, px_q, py_q, pz_q;
	logic signed [17:0] nx_q, ny_q, nz_q;
	logic [7:0] hmat_q;

	rsch_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.radicand(acc_q[rsch_pkg::RAD_W-1:0]),
		.done(sq_done),
		.root(sq_root)
	);

	rsch_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(dv_start),
		.dividend(dv_dividend),
		.divisor(dv_divisor),
		.done(dv_done),
		.quot(quot)
	);

	assign load_idx = rsch_pkg::IDX_W'(head.slot);

	always_comb begin
		mul_a = d_q[pc_q];
		mul_b = d_q[pc_q];
		case (phase_q)
			rsch_pkg::PH_A: begin
				mul_a = d_q[pc_q];
				mul_b = d_q[pc_q];
			end
			rsch_pkg::PH_H: begin
				mul_a = oc_q[pc_q];
				mul_b = d_q[pc_q];
			end
			rsch_pkg::PH_C: begin
				if (pc_q == 2'd3) begin
					mul_a = $signed({1'b0, rad_q[i_q]});
					mul_b = $signed({1'b0, rad_q[i_q]});
				end else begin
					mul_a = oc_q[pc_q];
					mul_b = oc_q[pc_q];
				end
			end
			rsch_pkg::PH_D: begin
				mul_a = (pc_q == 2'd0) ? h_q : a_q;
				mul_b = (pc_q == 2'd0) ? h_q : c_q;
			end
			rsch_pkg::PH_P: begin
				mul_a = d_q[pc_q];
				mul_b = best_t_q;
			end
			rsch_pkg::PH_N: begin
				mul_a = n_q[pc_q];
				mul_b = n_q[pc_q];
			end
			default: begin
				mul_a = d_q[pc_q];
				mul_b = d_q[pc_q];
			end
		endcase
	end

	always_comb begin
		term = rsch_pkg::f16(prod_q);
		last_pc = (pc_q == 2'd2);
		case (phase_q)
			rsch_pkg::PH_C: begin
				term = (pc_q == 2'd3) ? -rsch_pkg::f16(prod_q) : rsch_pkg::f16(prod_q);
				last_pc = (pc_q == 2'd3);
			end
			rsch_pkg::PH_D: begin
				term = (pc_q == 2'd0) ? rsch_pkg::ACC_W'(prod_q) : -rsch_pkg::ACC_W'(prod_q);
				last_pc = (pc_q == 2'd1);
			end
			rsch_pkg::PH_N: term = rsch_pkg::ACC_W'(prod_q);
			default: term = rsch_pkg::f16(prod_q);
		endcase
		acc_nx = ((pc_q == 2'd0) ? '0 : acc_q) + term;
	end

	assign p_nx = rsch_pkg::sat32(rsch_pkg::ACC_W'(o_q[pc_q]) + rsch_pkg::f16(prod_q));
	assign n_nx = rsch_pkg::sat32(rsch_pkg::ACC_W'(p_nx) - rsch_pkg::ACC_W'(cen_q[pc_q]));

	// t = (-h - s) * 2^16 / a, and normal = n * 2^16 / len, both on magnitudes
	assign num = -34'(h_q) - $signed({2'b00, sq_root});
	assign num_mag = num[33] ? 34'(-num) : 34'(num);
	assign nsel = n_q[pc_q];
	assign nmag = nsel[31] ? 32'(-nsel) : 32'(nsel);
	assign dv_dividend = (phase_q == rsch_pkg::PH_D) ?
		rsch_pkg::DIV_W'({num_mag[32:0], 16'h0000}) : rsch_pkg::DIV_W'({nmag, 16'h0000});
	assign dv_divisor = (phase_q == rsch_pkg::PH_D) ? a_q : sq_root;

	assign t_pos = (quot > rsch_pkg::POS_LIM) ? 32'sh7FFF_FFFF : $signed(quot[31:0]);
	assign t_neg = (quot > rsch_pkg::NEG_LIM) ? 32'sh8000_0000 : -$signed(quot[31:0]);
	assign t_val = tneg_q ? t_neg : t_pos;
	assign better = (t_val > rsch_pkg::EPS_RAW) && (!found_q || (t_val < best_t_q));
	assign nm = (quot > rsch_pkg::NORM_MAX) ? 18'd65536 : quot[17:0];
	assign nv = tneg_q ? -$signed(nm) : $signed(nm);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rsch_pkg::ST_IDLE: begin
				if (avail && head.op == rsch_pkg::OP_RAY) state_d = rsch_pkg::ST_MUL;
			end
			rsch_pkg::ST_SPH: state_d = valid_q[i_q] ? rsch_pkg::ST_MUL : rsch_pkg::ST_NEXT;
			rsch_pkg::ST_MUL: state_d = rsch_pkg::ST_ACC;
			rsch_pkg::ST_ACC: begin
				if (!last_pc) begin
					state_d = rsch_pkg::ST_MUL;
				end else begin
					case (phase_q)
						rsch_pkg::PH_A: state_d = (rsch_pkg::sat32(acc_nx) == 32'sd0) ?
							rsch_pkg::ST_RES : rsch_pkg::ST_SPH;
						rsch_pkg::PH_D: state_d = acc_nx[rsch_pkg::ACC_W-1] ?
							rsch_pkg::ST_NEXT : rsch_pkg::ST_SQ_GO;
						rsch_pkg::PH_N: state_d = rsch_pkg::ST_SQ_GO;
						default: state_d = rsch_pkg::ST_MUL;
					endcase
				end
			end
			rsch_pkg::ST_NEXT: begin
				if (i_q == rsch_pkg::IDX_W'(rsch_pkg::SPHERE_COUNT - 1)) begin
					state_d = found_q ? rsch_pkg::ST_MUL : rsch_pkg::ST_RES;
				end else begin
					state_d = rsch_pkg::ST_SPH;
				end
			end
			rsch_pkg::ST_SQ_GO: state_d = rsch_pkg::ST_SQ_WAIT;
			rsch_pkg::ST_SQ_WAIT: begin
				if (sq_done) begin
					if (phase_q == rsch_pkg::PH_D) state_d = rsch_pkg::ST_DV_GO;
					else state_d = (sq_root == '0) ? rsch_pkg::ST_RES : rsch_pkg::ST_DV_GO;
				end
			end
			rsch_pkg::ST_DV_GO: state_d = rsch_pkg::ST_DV_WAIT;
			rsch_pkg::ST_DV_WAIT: begin
				if (dv_done) begin
					if (phase_q == rsch_pkg::PH_D) state_d = rsch_pkg::ST_NEXT;
					else state_d = (pc_q == 2'd2) ? rsch_pkg::ST_RES : rsch_pkg::ST_DV_GO;
				end
			end
			rsch_pkg::ST_RES: begin
				if (!out_valid_q || pop) state_d = rsch_pkg::ST_IDLE;
			end
			default: state_d = rsch_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		take = (state_q == rsch_pkg::ST_IDLE) && avail;
		sq_start = (state_q == rsch_pkg::ST_SQ_GO);
		dv_start = (state_q == rsch_pkg::ST_DV_GO);
		out_load = (state_q == rsch_pkg::ST_RES) && (!out_valid_q || pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsch_pkg::ST_IDLE;
			phase_q <= rsch_pkg::PH_A;
			pc_q <= '0;
			i_q <= '0;
			valid_q <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				rsch_pkg::ST_IDLE: begin
					if (avail) begin
						if (head.op == rsch_pkg::OP_LOAD) begin
							valid_q[load_idx] <= 1'b1;
						end else begin
							phase_q <= rsch_pkg::PH_A;
							pc_q <= '0;
							i_q <= '0;
							found_q <= 1'b0;
						end
					end
				end
				rsch_pkg::ST_SPH: begin
					phase_q <= rsch_pkg::PH_H;
					pc_q <= '0;
				end
				rsch_pkg::ST_ACC: begin
					if (!last_pc) begin
						pc_q <= pc_q + 1'b1;
					end else begin
						pc_q <= '0;
						case (phase_q)
							rsch_pkg::PH_H: phase_q <= rsch_pkg::PH_C;
							rsch_pkg::PH_C: phase_q <= rsch_pkg::PH_D;
							rsch_pkg::PH_P: phase_q <= rsch_pkg::PH_N;
							default: phase_q <= phase_q;
						endcase
					end
				end
				rsch_pkg::ST_NEXT: begin
					if (i_q != rsch_pkg::IDX_W'(rsch_pkg::SPHERE_COUNT - 1)) begin
						i_q <= i_q + 1'b1;
					end else if (found_q) begin
						phase_q <= rsch_pkg::PH_P;
						pc_q <= '0;
					end
				end
				rsch_pkg::ST_DV_WAIT: begin
					if (dv_done) begin
						if (phase_q == rsch_pkg::PH_D) begin
							if (better) found_q <= 1'b1;
						end else if (pc_q != 2'd2) begin
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
			if (out_load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			rsch_pkg::ST_IDLE: begin
				if (avail) begin
					if (head.op == rsch_pkg::OP_LOAD) begin
						cx_q[load_idx] <= head.px;
						cy_q[load_idx] <= head.py;
						cz_q[load_idx] <= head.pz;
						rad_q[load_idx] <= head.radius;
						mat_q[load_idx] <= head.material;
					end else begin
						o_q[0] <= head.px;
						o_q[1] <= head.py;
						o_q[2] <= head.pz;
						d_q[0] <= head.dx;
						d_q[1] <= head.dy;
						d_q[2] <= head.dz;
					end
				end
			end
			rsch_pkg::ST_SPH: begin
				oc_q[0] <= rsch_pkg::sat32(rsch_pkg::ACC_W'(o_q[0]) - rsch_pkg::ACC_W'(cx_q[i_q]));
				oc_q[1] <= rsch_pkg::sat32(rsch_pkg::ACC_W'(o_q[1]) - rsch_pkg::ACC_W'(cy_q[i_q]));
				oc_q[2] <= rsch_pkg::sat32(rsch_pkg::ACC_W'(o_q[2]) - rsch_pkg::ACC_W'(cz_q[i_q]));
			end
			rsch_pkg::ST_ACC: begin
				acc_q <= acc_nx;
				case (phase_q)
					rsch_pkg::PH_A: if (last_pc) a_q <= rsch_pkg::sat32(acc_nx);
					rsch_pkg::PH_H: if (last_pc) h_q <= rsch_pkg::sat32(acc_nx);
					rsch_pkg::PH_C: if (last_pc) c_q <= rsch_pkg::sat32(acc_nx);
					rsch_pkg::PH_P: begin
						p_q[pc_q] <= p_nx;
						n_q[pc_q] <= n_nx;
					end
					default: ;
				endcase
			end
			rsch_pkg::ST_SQ_WAIT: begin
				if (sq_done && phase_q == rsch_pkg::PH_N && sq_root == '0) begin
					norm_q[0] <= '0;
					norm_q[1] <= '0;
					norm_q[2] <= '0;
				end
			end
			rsch_pkg::ST_DV_GO: begin
				tneg_q <= (phase_q == rsch_pkg::PH_D) ? num[33] : nsel[31];
			end
			rsch_pkg::ST_DV_WAIT: begin
				if (dv_done) begin
					if (phase_q == rsch_pkg::PH_D) begin
						if (better) begin
							best_t_q <= t_val;
							cen_q[0] <= cx_q[i_q];
							cen_q[1] <= cy_q[i_q];
							cen_q[2] <= cz_q[i_q];
							best_mat_q <= mat_q[i_q];
						end
					end else begin
						norm_q[pc_q] <= nv;
					end
				end
			end
			default: ;
		endcase
		if (out_load) begin
			hit_q <= found_q;
			dist_q <= found_q ? best_t_q : '0;
			px_q <= found_q ? p_q[0] : '0;
			py_q <= found_q ? p_q[1] : '0;
			pz_q <= found_q ? p_q[2] : '0;
			nx_q <= found_q ? norm_q[0] : '0;
			ny_q <= found_q ? norm_q[1] : '0;
			nz_q <= found_q ? norm_q[2] : '0;
			hmat_q <= found_q ? best_mat_q : '0;
		end
	end

	assign empty = ~out_valid_q;
	assign hit = hit_q;
	assign distance = dist_q;
	assign point_x = px_q;
	assign point_y = py_q;
	assign point_z = pz_q;
	assign normal_x = nx_q;
	assign normal_y = ny_q;
	assign normal_z = nz_q;
	assign hit_material = hmat_q;
endmodule

[design/ray_sphere_closest_hit.sv]
`timescale 1ns / 1ps
// Closest-hit ray caster over an 8-slot sphere table, signed Q16.16 (normals
// signed Q1.16). A word with action=0 loads one sphere slot and gives no
// result; a word with action=1 casts a ray and gives exactly one result word.
// Words go through a two-entry queue into one execution engine that handles
// them in order. The per-slot cost of a ray is set by the shared 32x32
// multiplier, the square root unit (2 radicand bits per cycle) and the
// restoring divider (1 quotient bit per cycle); the hit tail runs the square
// root once and then the divider three times unless that root is zero. A
// result word waits in an output register while the next word is taken.
module ray_sphere_closest_hit (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic action,
	input logic [2:0] slot,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] pos_z,
	input logic signed [31:0] dir_x,
	input logic signed [31:0] dir_y,
	input logic signed [31:0] dir_z,
	input logic [30:0] radius,
	input logic [7:0] material_id,
	output logic empty,
	input logic pop,
	output logic hit,
	output logic signed [31:0] distance,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic signed [17:0] normal_z,
	output logic [7:0] hit_material
);
	`include "ray_sphere_closest_hit_assert.svh"

	logic avail, take;
	rsch_pkg::item_t head;

	rsch_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.slot(slot),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z),
		.radius(radius),
		.material_id(material_id),
		.avail(avail),
		.head(head),
		.take(take)
	);

	rsch_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.avail(avail),
		.head(head),
		.take(take),
		.pop(pop),
		.empty(empty),
		.hit(hit),
		.distance(distance),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.hit_material(hit_material)
	);

	`RSCH_ASSERT_IMP(a_hit_beyond_eps, clk, arst_n, (!empty && hit), (distance > rsch_pkg::EPS_RAW), "hit with t not beyond epsilon")
	`RSCH_ASSERT_IMP(a_normal_range, clk, arst_n, (!empty && hit), ((normal_x <= 18'sd65536) && (normal_x >= -18'sd65536) && (normal_y <= 18'sd65536) && (normal_y >= -18'sd65536) && (normal_z <= 18'sd65536) && (normal_z >= -18'sd65536)), "normal out of range")
	`RSCH_ASSERT_ALW(a_miss_zero, clk, arst_n, (empty || hit || ((distance == 32'sd0) && (hit_material == 8'd0) && (point_x == 32'sd0) && (normal_x == 18'sd0))), "miss word not zero")
	`RSCH_ASSERT_IMP(a_take_needs_word, clk, arst_n, take, avail, "engine took from empty queue")
endmodule

[tb/tb_ray_sphere_closest_hit.sv]
`timescale 1ns / 1ps
module tb_ray_sphere_closest_hit;
	typedef struct packed {
		logic hit;
		logic signed [31:0] tval;
		logic signed [31:0] px, py, pz;
		logic signed [17:0] nx, ny, nz;
		logic [7:0] mat;
	} hit_rec_t;

	class hit_scoreboard;
		longint cx[rsch_pkg::SPHERE_COUNT], cy[rsch_pkg::SPHERE_COUNT];
		longint cz[rsch_pkg::SPHERE_COUNT], rad[rsch_pkg::SPHERE_COUNT];
		logic [7:0] mat[rsch_pkg::SPHERE_COUNT];
		bit vld[rsch_pkg::SPHERE_COUNT];
		hit_rec_t pending[$];
		int errors, words, rays, hits;

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint qmul(longint x, longint y);
			return (x * y) >>> 16;
		endfunction

		function longint isqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return longint'(r);
		endfunction

		function void note_word(rsch_pkg::op_t op, logic [2:0] s, longint ox, longint oy,
				longint oz, longint dx, longint dy, longint dz, logic [30:0] r,
				logic [7:0] m);
			longint o[3], d[3], cc[3], oc[3], p[3], n[3], a, h, c, disc, num, t, bt, rr, ln, nv;
			int bi, k, i;
			bit found;
			hit_rec_t e;
			if (op == rsch_pkg::OP_LOAD) begin
				cx[s] = ox; cy[s] = oy; cz[s] = oz; rad[s] = r; mat[s] = m; vld[s] = 1;
				return;
			end
			rays++;
			o = '{ox, oy, oz};
			d = '{dx, dy, dz};
			a = sat(qmul(d[0], d[0]) + qmul(d[1], d[1]) + qmul(d[2], d[2]));
			found = 0; bt = 0; bi = 0;
			for (i = 0; i < rsch_pkg::SPHERE_COUNT; i++) begin
				if (!vld[i] || a == 0) continue;
				cc = '{cx[i], cy[i], cz[i]};
				for (k = 0; k < 3; k++) oc[k] = sat(o[k] - cc[k]);
				rr = rad[i];
				h = sat(qmul(oc[0], d[0]) + qmul(oc[1], d[1]) + qmul(oc[2], d[2]));
				c = sat(qmul(oc[0], oc[0]) + qmul(oc[1], oc[1]) + qmul(oc[2], oc[2])
					- qmul(rr, rr));
				disc = h * h - a * c;
				if (disc < 0) continue;
				num = -h - isqrt(disc);
				t = sat((num * 65536) / a);
				if (t <= 6) continue;
				if (!found || t < bt) begin
					found = 1; bt = t; bi = i;
				end
			end
			e = '{default: 0};
			if (found) begin
				hits++;
				cc = '{cx[bi], cy[bi], cz[bi]};
				for (k = 0; k < 3; k++) begin
					p[k] = sat(o[k] + qmul(d[k], bt));
					n[k] = sat(p[k] - cc[k]);
				end
				ln = isqrt(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
				e.hit = 1; e.tval = 32'(bt);
				e.px = 32'(p[0]); e.py = 32'(p[1]); e.pz = 32'(p[2]);
				e.mat = mat[bi];
				for (k = 0; k < 3; k++) begin
					nv = 0;
					if (ln != 0) begin
						nv = (n[k] * 65536) / ln;
						if (nv > 65536) nv = 65536;
						if (nv < -65536) nv = -65536;
					end
					if (k == 0) e.nx = 18'(nv);
					else if (k == 1) e.ny = 18'(nv);
					else e.nz = 18'(nv);
				end
			end
			pending.push_back(e);
		endfunction

		function void check_word(hit_rec_t g);
			hit_rec_t e;
			words++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word hit=%0d", g.hit);
				return;
			end
			e = pending.pop_front();
			if (g !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch word %0d: exp %p got %p", words, e, g);
			end
		endfunction
	endclass

	logic clk, arst_n, push, full, action, empty, pop, hit;
	logic [2:0] slot;
	logic signed [31:0] pos_x, pos_y, pos_z, dir_x, dir_y, dir_z;
	logic [30:0] radius;
	logic [7:0] material_id, hit_material;
	logic signed [31:0] distance, point_x, point_y, point_z;
	logic signed [17:0] normal_x, normal_y, normal_z;

	hit_scoreboard sb;
	longint cycles;
	bit pop_hold;
	int loads_sent;

	ray_sphere_closest_hit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic signed [31:0] rnd_val(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
			default: return $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
		endcase
	endfunction

	task automatic send(rsch_pkg::op_t op, logic [2:0] s, logic signed [31:0] ox, oy, oz,
			dx, dy, dz, logic [30:0] r, logic [7:0] m);
		int g;
		g = gap_len();
		if (g > 0) begin
			push <= 0;
			repeat (g) @(negedge clk);
		end
		push <= 1; action <= op; slot <= s;
		pos_x <= ox; pos_y <= oy; pos_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		radius <= r; material_id <= m;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_word(op, s, ox, oy, oz, dx, dy, dz, r, m);
		if (op == rsch_pkg::OP_LOAD) loads_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	task automatic load_rnd(logic [2:0] s, int mode);
		send(rsch_pkg::OP_LOAD, s, rnd_val(mode), rnd_val(mode), rnd_val(mode), $urandom,
			$urandom, $urandom,
			(mode == 0) ? 31'($urandom) : 31'($urandom_range(1, 3 * 65536)),
			8'($urandom));
	endtask

	task automatic ray_rnd(int mode);
		send(rsch_pkg::OP_RAY, 3'($urandom), rnd_val(mode), rnd_val(mode), rnd_val(mode),
			rnd_val(mode), rnd_val(mode), rnd_val(mode), 31'($urandom), 8'($urandom));
	endtask

	// result side
	always @(posedge clk) begin
		hit_rec_t g;
		if (arst_n && pop && !empty) begin
			g.hit = hit; g.tval = distance; g.px = point_x; g.py = point_y; g.pz = point_z;
			g.nx = normal_x; g.ny = normal_y; g.nz = normal_z; g.mat = hit_material;
			sb.check_word(g);
		end
	end

	initial begin
		int g;
		pop = 0;
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g > 0 && !pop_hold) begin
				pop <= 0;
				repeat (g) @(negedge clk);
			end
			pop <= 1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int i, mode;
		sb = new();
		cycles = 0;
		clk = 0; arst_n = 0; push = 0; action = 0; slot = 0;
		pos_x = 0; pos_y = 0; pos_z = 0; dir_x = 0; dir_y = 0; dir_z = 0;
		radius = 0; material_id = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty table, zero dir, simple hits, tie, inside, extremes
		send(rsch_pkg::OP_RAY, 0, 0, 0, 0, 65536, 0, 0, 0, 0);
		send(rsch_pkg::OP_LOAD, 0, 5 * 65536, 0, 0, 0, 0, 0, 65536, 8'h11);
		send(rsch_pkg::OP_RAY, 7, 0, 0, 0, 65536, 0, 0, 0, 0);
		send(rsch_pkg::OP_RAY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send(rsch_pkg::OP_RAY, 0, 0, 0, 0, 1, 1, 1, 0, 0);
		send(rsch_pkg::OP_RAY, 0, 0, 0, 0, -65536, 0, 0, 0, 0);
		send(rsch_pkg::OP_RAY, 0, 0, 0, 0, 0, 65536, 0, 0, 0);
		send(rsch_pkg::OP_LOAD, 3, 5 * 65536, 0, 0, 0, 0, 0, 65536, 8'hEE);
		send(rsch_pkg::OP_RAY, 0, 0, 0, 0, 2 * 65536, 0, 0, 0, 0);
		send(rsch_pkg::OP_RAY, 0, 5 * 65536, 0, 0, 65536, 0, 0, 0, 0);
		send(rsch_pkg::OP_RAY, 0, 4 * 65536, 0, 0, 65536, 0, 0, 0, 0);
		send(rsch_pkg::OP_LOAD, 7, 0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 8'hFF);
		send(rsch_pkg::OP_RAY, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
		send(rsch_pkg::OP_RAY, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
		send(rsch_pkg::OP_LOAD, 7, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, -1, -1, 0, 0);
		send(rsch_pkg::OP_RAY, 0, 0, 0, 0, 65536, 65536, 65536, 0, 0);

		// wait for every result before continuing
		drain();

		for (i = 0; i < 600; i++) begin
			mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
			if (i == 300) begin
				drain();
				pop_hold = 1;
			end
			if (i == 400) pop_hold = 0;
			if ($urandom_range(0, 99) < 15) load_rnd(3'($urandom), mode);
			else ray_rnd(mode);
		end

		drain();
		repeat (50) @(negedge clk);
		$display("%0d sphere loads and %0d rays sent, %0d result words checked, %0d hits",
			loads_sent, sb.rays, sb.words, sb.hits);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
